// ===== src/mvng_pkg.sv =====
`default_nettype none
package mvng_pkg;

  localparam int MAX_VERTICES_DEF = 1024;
  localparam int IDX_W = 10;
  localparam int POS_W = 16;
  localparam int VCOUNT_W = 11;
  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 11'd1024;
  localparam int SUM_W = 48;
  localparam int FN_W = 36;
  localparam int NRM_W = 16;
  localparam int STAT_W = 2;

  localparam logic [1:0] KIND_POS   = 2'd0;
  localparam logic [1:0] KIND_TRI   = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_INDEX = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ZERO_SUM  = 2'd2;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_POS_WR, S_TRI_CHK, S_TRI_RA, S_TRI_RB, S_TRI_RC, S_TRI_CAP,
    S_CROSS, S_FIX, S_SUM_RD, S_SUM_WR, S_NRM_RD, S_NRM_CAP, S_NORM, S_SQ,
    S_SQRT, S_DIV_LD, S_DIV, S_EMIT
  } state_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_CLR_STEP, OP_POS_WR, OP_TRI_CHK, OP_RD_A, OP_RD_B, OP_RD_C,
    OP_CAP_C, OP_CROSS, OP_FIX, OP_SUM_RD, OP_SUM_WR, OP_NRM_RD, OP_NRM_CAP,
    OP_NORM, OP_SQ, OP_SQRT, OP_DIV_LD, OP_DIV
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   in_load;
    logic   out_load;
    logic   step_clr;
    logic   comp_clr;
    logic   comp_inc;
  } cmd_t;

  typedef struct packed {
    logic tri_bad;
    logic rd_beyond;
    logic nrm_zero;
    logic nrm_ok;
    logic cross_done;
    logic sq_done;
    logic sqrt_done;
    logic div_done;
    logic comp_last;
    logic clr_last;
  } sts_t;

endpackage
`default_nettype wire

// ===== src/mesh_vertex_normal_generator_top.sv =====
`default_nettype none
// channel   handshake             payload
// in        in_valid / in_stall   in_kind in_vertex_index in_pos_x/y/z in_corner_a/b/c
// out       out_valid / out_stall out_normal_x/y/z out_which_vertex out_status
// cfg       cfg_valid / cfg_ready cfg_data (vertex_count)
//
// position write: one write to the position memory; triangle: three position reads, the
// six cross-product terms on the shared multiplier, three read-modify-writes of the sum
// memory, or an index-error result when a corner is bad; normal read: the one-bit-a-cycle
// normalizing shift, the 32-step square root and the divider once per component
// reset or a clear beat runs a clearing pass over the sum memory before in is taken
// a finished result sits in the output register while the next beat is taken; a further
// result waits, with in stalled, until that register is taken
module mesh_vertex_normal_generator_top #(
  parameter int MAX_VERTICES = mvng_pkg::MAX_VERTICES_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic        [1:0]                    in_kind,
  input  wire logic        [mvng_pkg::IDX_W-1:0]    in_vertex_index,
  input  wire logic signed [mvng_pkg::POS_W-1:0]    in_pos_x,
  input  wire logic signed [mvng_pkg::POS_W-1:0]    in_pos_y,
  input  wire logic signed [mvng_pkg::POS_W-1:0]    in_pos_z,
  input  wire logic        [mvng_pkg::IDX_W-1:0]    in_corner_a,
  input  wire logic        [mvng_pkg::IDX_W-1:0]    in_corner_b,
  input  wire logic        [mvng_pkg::IDX_W-1:0]    in_corner_c,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed      [mvng_pkg::NRM_W-1:0]    out_normal_x,
  output logic signed      [mvng_pkg::NRM_W-1:0]    out_normal_y,
  output logic signed      [mvng_pkg::NRM_W-1:0]    out_normal_z,
  output logic             [mvng_pkg::IDX_W-1:0]    out_which_vertex,
  output logic             [mvng_pkg::STAT_W-1:0]   out_status,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic        [mvng_pkg::VCOUNT_W-1:0] cfg_data
);

  mvng_pkg::cmd_t cmd;
  mvng_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  mvng_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mvng_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_valid        (cfg_valid),
    .cfg_data         (cfg_data),
    .in_vertex_index  (in_vertex_index),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_pos_z         (in_pos_z),
    .in_corner_a      (in_corner_a),
    .in_corner_b      (in_corner_b),
    .in_corner_c      (in_corner_c),
    .out_normal_x     (out_normal_x),
    .out_normal_y     (out_normal_y),
    .out_normal_z     (out_normal_z),
    .out_which_vertex (out_which_vertex),
    .out_status       (out_status)
  );

endmodule
`default_nettype wire

// ===== src/mvng_ram.sv =====
`default_nettype none
module mvng_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0]  waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0]  raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/mvng_ctrl.sv =====
`default_nettype none
module mvng_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic [1:0]     in_kind,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  input  wire mvng_pkg::sts_t sts,
  output mvng_pkg::cmd_t      cmd
);

  mvng_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != mvng_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mvng_pkg::S_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mvng_pkg::S_CLR:     if (sts.clr_last) state_nxt = mvng_pkg::S_IDLE;
      mvng_pkg::S_IDLE: begin
        if (in_valid) begin
          unique case (in_kind)
            mvng_pkg::KIND_POS:  state_nxt = mvng_pkg::S_POS_WR;
            mvng_pkg::KIND_TRI:  state_nxt = mvng_pkg::S_TRI_CHK;
            mvng_pkg::KIND_READ: state_nxt = mvng_pkg::S_NRM_RD;
            default:             state_nxt = mvng_pkg::S_CLR;
          endcase
        end
      end
      mvng_pkg::S_POS_WR:  state_nxt = mvng_pkg::S_IDLE;
      mvng_pkg::S_TRI_CHK: state_nxt = sts.tri_bad ? mvng_pkg::S_EMIT : mvng_pkg::S_TRI_RA;
      mvng_pkg::S_TRI_RA:  state_nxt = mvng_pkg::S_TRI_RB;
      mvng_pkg::S_TRI_RB:  state_nxt = mvng_pkg::S_TRI_RC;
      mvng_pkg::S_TRI_RC:  state_nxt = mvng_pkg::S_TRI_CAP;
      mvng_pkg::S_TRI_CAP: state_nxt = mvng_pkg::S_CROSS;
      mvng_pkg::S_CROSS:   if (sts.cross_done) state_nxt = mvng_pkg::S_FIX;
      mvng_pkg::S_FIX:     state_nxt = mvng_pkg::S_SUM_RD;
      mvng_pkg::S_SUM_RD:  state_nxt = mvng_pkg::S_SUM_WR;
      mvng_pkg::S_SUM_WR:
        state_nxt = sts.comp_last ? mvng_pkg::S_IDLE : mvng_pkg::S_SUM_RD;
      mvng_pkg::S_NRM_RD:
        state_nxt = sts.rd_beyond ? mvng_pkg::S_EMIT : mvng_pkg::S_NRM_CAP;
      mvng_pkg::S_NRM_CAP: state_nxt = mvng_pkg::S_NORM;
      mvng_pkg::S_NORM: begin
        priority if (sts.nrm_zero) state_nxt = mvng_pkg::S_EMIT;
        else if (sts.nrm_ok)       state_nxt = mvng_pkg::S_SQ;
        else                       state_nxt = mvng_pkg::S_NORM;
      end
      mvng_pkg::S_SQ:      if (sts.sq_done) state_nxt = mvng_pkg::S_SQRT;
      mvng_pkg::S_SQRT:    if (sts.sqrt_done) state_nxt = mvng_pkg::S_DIV_LD;
      mvng_pkg::S_DIV_LD:  state_nxt = mvng_pkg::S_DIV;
      mvng_pkg::S_DIV: begin
        if (sts.div_done) begin
          state_nxt = sts.comp_last ? mvng_pkg::S_EMIT : mvng_pkg::S_DIV_LD;
        end
      end
      mvng_pkg::S_EMIT:    if (out_free) state_nxt = mvng_pkg::S_IDLE;
      default:             state_nxt = mvng_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.op        = mvng_pkg::OP_NOP;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      mvng_pkg::S_CLR:     cmd.op = mvng_pkg::OP_CLR_STEP;
      mvng_pkg::S_IDLE:    cmd.in_load = in_valid;
      mvng_pkg::S_POS_WR:  cmd.op = mvng_pkg::OP_POS_WR;
      mvng_pkg::S_TRI_CHK: cmd.op = mvng_pkg::OP_TRI_CHK;
      mvng_pkg::S_TRI_RA:  cmd.op = mvng_pkg::OP_RD_A;
      mvng_pkg::S_TRI_RB:  cmd.op = mvng_pkg::OP_RD_B;
      mvng_pkg::S_TRI_RC:  cmd.op = mvng_pkg::OP_RD_C;
      mvng_pkg::S_TRI_CAP: begin
        cmd.op       = mvng_pkg::OP_CAP_C;
        cmd.step_clr = 1'b1;
      end
      mvng_pkg::S_CROSS:   cmd.op = mvng_pkg::OP_CROSS;
      mvng_pkg::S_FIX: begin
        cmd.op       = mvng_pkg::OP_FIX;
        cmd.comp_clr = 1'b1;
      end
      mvng_pkg::S_SUM_RD:  cmd.op = mvng_pkg::OP_SUM_RD;
      mvng_pkg::S_SUM_WR: begin
        cmd.op       = mvng_pkg::OP_SUM_WR;
        cmd.comp_inc = 1'b1;
      end
      mvng_pkg::S_NRM_RD:  cmd.op = mvng_pkg::OP_NRM_RD;
      mvng_pkg::S_NRM_CAP: cmd.op = mvng_pkg::OP_NRM_CAP;
      mvng_pkg::S_NORM: begin
        cmd.op       = mvng_pkg::OP_NORM;
        cmd.step_clr = 1'b1;
      end
      mvng_pkg::S_SQ: begin
        cmd.op       = mvng_pkg::OP_SQ;
        cmd.step_clr = sts.sq_done;
      end
      mvng_pkg::S_SQRT: begin
        cmd.op       = mvng_pkg::OP_SQRT;
        cmd.comp_clr = sts.sqrt_done;
      end
      mvng_pkg::S_DIV_LD: begin
        cmd.op       = mvng_pkg::OP_DIV_LD;
        cmd.step_clr = 1'b1;
      end
      mvng_pkg::S_DIV: begin
        cmd.op       = mvng_pkg::OP_DIV;
        cmd.comp_inc = sts.div_done;
      end
      mvng_pkg::S_EMIT: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd.op = mvng_pkg::OP_NOP;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/mvng_dp.sv =====
`default_nettype none
module mvng_dp #(
  parameter int MAX_VERTICES = mvng_pkg::MAX_VERTICES_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire mvng_pkg::cmd_t                         cmd,
  output mvng_pkg::sts_t                              sts,
  input  wire logic                                   cfg_valid,
  input  wire logic        [mvng_pkg::VCOUNT_W-1:0]   cfg_data,
  input  wire logic        [mvng_pkg::IDX_W-1:0]      in_vertex_index,
  input  wire logic signed [mvng_pkg::POS_W-1:0]      in_pos_x,
  input  wire logic signed [mvng_pkg::POS_W-1:0]      in_pos_y,
  input  wire logic signed [mvng_pkg::POS_W-1:0]      in_pos_z,
  input  wire logic        [mvng_pkg::IDX_W-1:0]      in_corner_a,
  input  wire logic        [mvng_pkg::IDX_W-1:0]      in_corner_b,
  input  wire logic        [mvng_pkg::IDX_W-1:0]      in_corner_c,
  output logic signed      [mvng_pkg::NRM_W-1:0]      out_normal_x,
  output logic signed      [mvng_pkg::NRM_W-1:0]      out_normal_y,
  output logic signed      [mvng_pkg::NRM_W-1:0]      out_normal_z,
  output logic             [mvng_pkg::IDX_W-1:0]      out_which_vertex,
  output logic             [mvng_pkg::STAT_W-1:0]     out_status
);

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int IW = mvng_pkg::IDX_W;
  localparam int PW = mvng_pkg::POS_W;
  localparam int SW = mvng_pkg::SUM_W;
  localparam int FW = mvng_pkg::FN_W;
  localparam int NW = mvng_pkg::NRM_W;

  function automatic logic beyond(input logic [IW-1:0] i);
    return 32'(i) >= 32'(MAX_VERTICES);
  endfunction

  function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] s, input logic [FW-1:0] d);
    logic [SW:0] r;
    r = {s[SW-1], s} + {{(SW+1-FW){d[FW-1]}}, d};
    if (r[SW] != r[SW-1]) begin
      return r[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end
    return r[SW-1:0];
  endfunction

  function automatic logic [SW-1:0] abs_sum(input logic [SW-1:0] s);
    return s[SW-1] ? (~s + SW'(1)) : s;
  endfunction

  // latched input beat and configuration
  logic [mvng_pkg::VCOUNT_W-1:0] vcount_r;
  logic [IW-1:0] idx_r, ca_r, cb_r, cc_r;
  logic [PW-1:0] px_r, py_r, pz_r;

  // control counters
  logic [4:0]    step_r;
  logic [1:0]    comp_r;
  logic [AW-1:0] clr_r;

  // memories
  logic            pos_we;
  logic [AW-1:0]   pos_raddr;
  logic [3*PW-1:0] pos_rdata;
  logic            sum_we;
  logic [AW-1:0]   sum_waddr, sum_raddr;
  logic [3*SW-1:0] sum_wdata, sum_rdata;

  // triangle datapath
  logic [3*PW-1:0] v0_r, v1_r;
  logic [PW:0]     e1x_r, e1y_r, e1z_r, e2x_r, e2y_r, e2z_r;
  logic [FW-1:0]   nx_r, ny_r, nz_r, prod36;
  logic [IW-1:0]   corner;
  logic            bad_a, bad_b, bad_c;

  // shared multiplier
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_r;

  // normalization datapath
  logic [SW-1:0] ax_r, ay_r, az_r, m, a_sel;
  logic [2:0]    sg_r;
  logic [63:0]   acc_r, root_r, sq_bit, sq_try;
  logic [46:0]   drem_r, dsh;
  logic [3:0]    dbit;
  logic [15:0]   q_r, q_nxt, q_clamp;
  logic [NW-1:0] q_signed;
  logic          d_ge;

  // result held for the output register
  logic [NW-1:0]   res_x_r, res_y_r, res_z_r;
  logic [IW-1:0]   res_which_r;
  logic [mvng_pkg::STAT_W-1:0] res_status_r;

  mvng_ram #(.WIDTH(3*PW), .DEPTH(MAX_VERTICES)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (AW'(idx_r)),
    .wdata ({px_r, py_r, pz_r}),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  mvng_ram #(.WIDTH(3*SW), .DEPTH(MAX_VERTICES)) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .raddr (sum_raddr),
    .rdata (sum_rdata)
  );

  assign bad_a = ({1'b0, ca_r} >= vcount_r) || beyond(ca_r);
  assign bad_b = ({1'b0, cb_r} >= vcount_r) || beyond(cb_r);
  assign bad_c = ({1'b0, cc_r} >= vcount_r) || beyond(cc_r);

  always_comb begin
    unique case (comp_r)
      2'd0:    corner = ca_r;
      2'd1:    corner = cb_r;
      default: corner = cc_r;
    endcase
  end

  always_comb begin
    unique case (cmd.op)
      mvng_pkg::OP_RD_B: pos_raddr = AW'(cb_r);
      mvng_pkg::OP_RD_C: pos_raddr = AW'(cc_r);
      default:           pos_raddr = AW'(ca_r);
    endcase
  end

  assign pos_we    = (cmd.op == mvng_pkg::OP_POS_WR) && !beyond(idx_r);
  assign sum_we    = (cmd.op == mvng_pkg::OP_CLR_STEP) || (cmd.op == mvng_pkg::OP_SUM_WR);
  assign sum_waddr = (cmd.op == mvng_pkg::OP_CLR_STEP) ? clr_r : AW'(corner);
  assign sum_raddr = (cmd.op == mvng_pkg::OP_SUM_RD) ? AW'(corner) : AW'(idx_r);
  assign sum_wdata = (cmd.op == mvng_pkg::OP_CLR_STEP) ? '0 :
                     {sat_add(sum_rdata[3*SW-1:2*SW], nx_r),
                      sat_add(sum_rdata[2*SW-1:SW], ny_r),
                      sat_add(sum_rdata[SW-1:0], nz_r)};

  // multiplier operands: cross product terms, then squares
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.op == mvng_pkg::OP_CROSS) begin
      unique case (step_r)
        5'd0: begin mul_a = 32'(signed'(e1y_r)); mul_b = 32'(signed'(e2z_r)); end
        5'd1: begin mul_a = 32'(signed'(e1z_r)); mul_b = 32'(signed'(e2y_r)); end
        5'd2: begin mul_a = 32'(signed'(e1z_r)); mul_b = 32'(signed'(e2x_r)); end
        5'd3: begin mul_a = 32'(signed'(e1x_r)); mul_b = 32'(signed'(e2z_r)); end
        5'd4: begin mul_a = 32'(signed'(e1x_r)); mul_b = 32'(signed'(e2y_r)); end
        5'd5: begin mul_a = 32'(signed'(e1y_r)); mul_b = 32'(signed'(e2x_r)); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (cmd.op == mvng_pkg::OP_SQ) begin
      mul_a = signed'({2'b00, a_sel[29:0]});
      mul_b = signed'({2'b00, a_sel[29:0]});
    end
  end

  always_comb begin
    logic [1:0] k;
    k = (cmd.op == mvng_pkg::OP_SQ) ? step_r[1:0] : comp_r;
    unique case (k)
      2'd0:    a_sel = ax_r;
      2'd1:    a_sel = ay_r;
      default: a_sel = az_r;
    endcase
  end

  assign prod36 = mul_r[FW-1:0];

  always_comb begin
    m = ax_r;
    if (ay_r > m) m = ay_r;
    if (az_r > m) m = az_r;
  end

  // one root bit per step, from 2^62 down
  assign sq_bit = 64'(1) << (6'd62 - {step_r, 1'b0});
  assign sq_try = root_r + sq_bit;

  // one quotient bit per step, msb first
  assign dbit     = 4'hF - step_r[3:0];
  assign dsh      = 47'(root_r[31:0]) << dbit;
  assign d_ge     = drem_r >= dsh;
  assign q_nxt    = q_r | (d_ge ? (16'(1) << dbit) : 16'(0));
  assign q_clamp  = (q_nxt > 16'd16384) ? 16'd16384 : q_nxt;
  assign q_signed = sg_r[2'd2 - comp_r] ? (~q_clamp + 16'(1)) : q_clamp;

  always_comb begin
    sts            = '0;
    sts.tri_bad    = bad_a || bad_b || bad_c;
    sts.rd_beyond  = beyond(idx_r);
    sts.nrm_zero   = (m == '0);
    sts.nrm_ok     = (m[SW-1:30] == '0) && m[29];
    sts.cross_done = (step_r == 5'd6);
    sts.sq_done    = (step_r == 5'd3);
    sts.sqrt_done  = (step_r == 5'd31);
    sts.div_done   = (step_r == 5'd15);
    sts.comp_last  = (comp_r == 2'd2);
    sts.clr_last   = (clr_r == AW'(MAX_VERTICES - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= mvng_pkg::VCOUNT_RESET;
      step_r   <= '0;
      comp_r   <= '0;
      clr_r    <= '0;
    end else begin
      if (cfg_valid) vcount_r <= cfg_data;
      if (cmd.step_clr) begin
        step_r <= '0;
      end else if (cmd.op == mvng_pkg::OP_CROSS || cmd.op == mvng_pkg::OP_SQ ||
                   cmd.op == mvng_pkg::OP_SQRT  || cmd.op == mvng_pkg::OP_DIV) begin
        step_r <= step_r + 5'd1;
      end
      if (cmd.comp_clr)      comp_r <= '0;
      else if (cmd.comp_inc) comp_r <= comp_r + 2'd1;
      if (cmd.op == mvng_pkg::OP_CLR_STEP) begin
        clr_r <= sts.clr_last ? '0 : clr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
    if (cmd.in_load) begin
      idx_r <= in_vertex_index;
      px_r  <= in_pos_x;
      py_r  <= in_pos_y;
      pz_r  <= in_pos_z;
      ca_r  <= in_corner_a;
      cb_r  <= in_corner_b;
      cc_r  <= in_corner_c;
    end
    if (cmd.out_load) begin
      out_normal_x     <= res_x_r;
      out_normal_y     <= res_y_r;
      out_normal_z     <= res_z_r;
      out_which_vertex <= res_which_r;
      out_status       <= res_status_r;
    end
    unique case (cmd.op)
      mvng_pkg::OP_TRI_CHK: begin
        res_x_r      <= '0;
        res_y_r      <= '0;
        res_z_r      <= '0;
        res_status_r <= mvng_pkg::STAT_BAD_INDEX;
        priority if (bad_a) res_which_r <= ca_r;
        else if (bad_b)     res_which_r <= cb_r;
        else                res_which_r <= cc_r;
      end
      mvng_pkg::OP_RD_B: v0_r <= pos_rdata;
      mvng_pkg::OP_RD_C: v1_r <= pos_rdata;
      mvng_pkg::OP_CAP_C: begin
        e1x_r <= {v1_r[47], v1_r[47:32]} - {v0_r[47], v0_r[47:32]};
        e1y_r <= {v1_r[31], v1_r[31:16]} - {v0_r[31], v0_r[31:16]};
        e1z_r <= {v1_r[15], v1_r[15:0]}  - {v0_r[15], v0_r[15:0]};
        e2x_r <= {pos_rdata[47], pos_rdata[47:32]} - {v0_r[47], v0_r[47:32]};
        e2y_r <= {pos_rdata[31], pos_rdata[31:16]} - {v0_r[31], v0_r[31:16]};
        e2z_r <= {pos_rdata[15], pos_rdata[15:0]}  - {v0_r[15], v0_r[15:0]};
      end
      mvng_pkg::OP_CROSS: begin
        // the product registered for step k is used here at step k+1
        unique case (step_r)
          5'd1:    nx_r <= prod36;
          5'd2:    nx_r <= nx_r - prod36;
          5'd3:    ny_r <= prod36;
          5'd4:    ny_r <= ny_r - prod36;
          5'd5:    nz_r <= prod36;
          5'd6:    nz_r <= nz_r - prod36;
          default: nz_r <= nz_r;
        endcase
      end
      mvng_pkg::OP_FIX: begin
        // degenerate face counts as one unit along x
        if (nx_r == '0 && ny_r == '0 && nz_r == '0) nx_r <= FW'(65536);
      end
      mvng_pkg::OP_NRM_RD: begin
        res_x_r      <= '0;
        res_y_r      <= '0;
        res_z_r      <= '0;
        res_which_r  <= idx_r;
        res_status_r <= beyond(idx_r) ? mvng_pkg::STAT_ZERO_SUM : mvng_pkg::STAT_OK;
      end
      mvng_pkg::OP_NRM_CAP: begin
        ax_r <= abs_sum(sum_rdata[3*SW-1:2*SW]);
        ay_r <= abs_sum(sum_rdata[2*SW-1:SW]);
        az_r <= abs_sum(sum_rdata[SW-1:0]);
        sg_r <= {sum_rdata[3*SW-1], sum_rdata[2*SW-1], sum_rdata[SW-1]};
      end
      mvng_pkg::OP_NORM: begin
        priority if (m == '0) begin
          res_status_r <= mvng_pkg::STAT_ZERO_SUM;
        end else if (m[SW-1:30] != '0) begin
          ax_r <= ax_r >> 1;
          ay_r <= ay_r >> 1;
          az_r <= az_r >> 1;
        end else if (!m[29]) begin
          ax_r <= ax_r << 1;
          ay_r <= ay_r << 1;
          az_r <= az_r << 1;
        end else begin
          // already in range, nothing to shift
        end
      end
      mvng_pkg::OP_SQ: begin
        priority case (step_r)
          5'd0:    root_r <= '0;
          5'd1:    acc_r  <= 64'(mul_r);
          default: acc_r  <= acc_r + 64'(mul_r);
        endcase
      end
      mvng_pkg::OP_SQRT: begin
        if (acc_r >= sq_try) begin
          acc_r  <= acc_r - sq_try;
          root_r <= (root_r >> 1) + sq_bit;
        end else begin
          root_r <= root_r >> 1;
        end
      end
      mvng_pkg::OP_DIV_LD: begin
        drem_r <= 47'({a_sel[29:0], 14'b0}) + 47'(root_r[31:1]);
        q_r    <= '0;
      end
      mvng_pkg::OP_DIV: begin
        if (d_ge) drem_r <= drem_r - dsh;
        q_r <= q_nxt;
        if (sts.div_done) begin
          unique case (comp_r)
            2'd0:    res_x_r <= q_signed;
            2'd1:    res_y_r <= q_signed;
            default: res_z_r <= q_signed;
          endcase
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire
